// ----- rtl/tce_pkg.sv -----
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types and constants for the transitive closure engine: word
// layouts, operation and status codes, controller states and the command
// and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package tce_pkg;

   localparam int MAX_VERTICES_DEFAULT = 64;

   // Width of the vertex count register.
   localparam int COUNT_W = 7;
   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

   localparam logic [1:0] OP_CLEAR   = 2'd0;
   localparam logic [1:0] OP_ADD     = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;
   localparam logic [1:0] OP_QUERY   = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_RANGE   = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [5:0] src_vertex;
      logic [5:0] dst_vertex;
   } tce_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        reachable;
      logic [63:0] reachable_row;
      logic [12:0] pair_count;
   } tce_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD_RD,
      S_ADD_WR,
      S_CPY_RD,
      S_CPY_WR,
      S_PIV_RD,
      S_PIV_LD,
      S_ROW_RD,
      S_ROW_WR,
      S_CNT_RD,
      S_CNT_ACC,
      S_QRY_RD,
      S_RESP
   } tce_state_type;

   typedef struct packed {
      logic latch;     // capture the accepted word
      logic clear;     // reset adjacency to identity, drop the closure
      logic i_zero;
      logic i_inc;
      logic k_zero;
      logic k_inc;
      logic adj_rd;    // read adjacency row of the source vertex
      logic adj_wr;    // write it back with the new edge
      logic cpy_rd;    // read adjacency row i
      logic cpy_wr;    // write closure row i from it
      logic piv_rd;    // read closure row k
      logic piv_ld;    // hold it as the pivot row
      logic row_rd;    // read closure row i
      logic row_wr;    // merge the pivot row into it if it reaches k
      logic acc_clr;
      logic cnt_rd;    // read closure row i for counting
      logic cnt_acc;
      logic cnt_done;  // store the total and mark the closure valid
      logic qry_rd;    // read closure row of the source vertex
      logic out_load;
   } tce_cmd_type;

   typedef struct packed {
      logic range_err;
      logic closure_valid;
      logic row_last;
      logic copy_last;
      logic pivot_last;
      logic out_free;
   } tce_sts_type;

endpackage

// ----- rtl/tce_datapath.sv -----
// ----------------------------------------------------------------------------
// tce_datapath
// Adjacency and closure row memories, row and pivot counters, pair counter,
// configuration register and the output register.
// ----------------------------------------------------------------------------
module tce_datapath #(
   parameter int MAX_VERTICES = tce_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tce_pkg::tce_req_type           req_data,
   input  tce_pkg::tce_cmd_type           cmd,
   output tce_pkg::tce_sts_type           sts,
   input  logic                           csr_wr_en,
   input  logic [tce_pkg::COUNT_W-1:0]    csr_wr_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tce_pkg::tce_rsp_type           rsp_data
);
   import tce_pkg::*;

   localparam int VIDX_W = $clog2(MAX_VERTICES);
   localparam int ROW_W  = MAX_VERTICES;

   logic [ROW_W-1:0]   adj_mem [MAX_VERTICES];
   logic [ROW_W-1:0]   clo_mem [MAX_VERTICES];
   logic [ROW_W-1:0]   adj_vld_ff;

   tce_req_type        item_ff;
   logic [COUNT_W-1:0] vc_ff;
   logic               valid_ff;
   logic [12:0]        pair_total_ff;
   logic [12:0]        acc_ff;
   logic [VIDX_W-1:0]  i_ff;
   logic [VIDX_W-1:0]  k_ff;

   logic [ROW_W-1:0]   adj_rd_ff;
   logic               adj_rd_vld_ff;
   logic [VIDX_W-1:0]  adj_rd_idx_ff;
   logic [ROW_W-1:0]   clo_rd_ff;
   logic [ROW_W-1:0]   pivot_ff;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   tce_rsp_type        rsp_ff;
   tce_rsp_type        rsp_in;

   logic [COUNT_W-1:0] n_eff;
   logic [ROW_W-1:0]   mask;
   logic [VIDX_W-1:0]  src_idx;
   logic [VIDX_W-1:0]  dst_idx;
   logic [ROW_W-1:0]   adj_row;
   logic [ROW_W-1:0]   qry_row;
   logic [12:0]        acc_in;
   logic               adj_rd_en;
   logic [VIDX_W-1:0]  adj_rd_addr;
   logic               clo_rd_en;
   logic [VIDX_W-1:0]  clo_rd_addr;

   // Active vertex count: zero counts as one, larger values are clamped.
   always_comb begin
      if (vc_ff == '0) begin
         n_eff = COUNT_W'(1);
      end else if (vc_ff > COUNT_W'(MAX_VERTICES)) begin
         n_eff = COUNT_W'(MAX_VERTICES);
      end else begin
         n_eff = vc_ff;
      end
   end

   always_comb begin
      for (int j = 0; j < ROW_W; j++) begin
         mask[j] = (COUNT_W'(j) < n_eff);
      end
   end

   assign src_idx = item_ff.src_vertex[VIDX_W-1:0];
   assign dst_idx = item_ff.dst_vertex[VIDX_W-1:0];

   // A row never written since the last clear reads as its identity row.
   assign adj_row = adj_rd_vld_ff ? adj_rd_ff : (ROW_W'(1) << adj_rd_idx_ff);
   assign qry_row = clo_rd_ff & mask;
   assign acc_in  = acc_ff + 13'($countones(clo_rd_ff));

   assign sts.range_err     = (COUNT_W'(item_ff.src_vertex) >= n_eff) ||
                              (COUNT_W'(item_ff.dst_vertex) >= n_eff);
   assign sts.closure_valid = valid_ff;
   assign sts.row_last      = (i_ff == VIDX_W'(n_eff - COUNT_W'(1)));
   assign sts.copy_last     = (i_ff == VIDX_W'(MAX_VERTICES - 1));
   assign sts.pivot_last    = (k_ff == VIDX_W'(n_eff - COUNT_W'(1)));
   assign sts.out_free      = !rsp_valid_ff || !rsp_stall;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff         <= VERTEX_COUNT_RESET;
         valid_ff      <= 1'b0;
         pair_total_ff <= '0;
         acc_ff        <= '0;
         i_ff          <= '0;
         k_ff          <= '0;
         adj_vld_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            vc_ff    <= csr_wr_data;
            valid_ff <= 1'b0;
         end
         if (cmd.clear) begin
            adj_vld_ff    <= '0;
            valid_ff      <= 1'b0;
            pair_total_ff <= '0;
         end
         if (cmd.adj_wr) begin
            adj_vld_ff[src_idx] <= 1'b1;
         end
         if (cmd.i_zero) begin
            i_ff <= '0;
         end else if (cmd.i_inc) begin
            i_ff <= i_ff + VIDX_W'(1);
         end
         if (cmd.k_zero) begin
            k_ff <= '0;
         end else if (cmd.k_inc) begin
            k_ff <= k_ff + VIDX_W'(1);
         end
         if (cmd.acc_clr) begin
            acc_ff <= '0;
         end else if (cmd.cnt_acc) begin
            acc_ff <= acc_in;
         end
         if (cmd.cnt_done) begin
            pair_total_ff <= acc_in;
            valid_ff      <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         item_ff <= req_data;
      end
      if (cmd.piv_ld) begin
         pivot_ff <= clo_rd_ff;
      end
   end

   // Adjacency memory.
   assign adj_rd_en   = cmd.adj_rd || cmd.cpy_rd;
   assign adj_rd_addr = cmd.cpy_rd ? i_ff : src_idx;

   always_ff @(posedge clock) begin
      if (adj_rd_en) begin
         adj_rd_ff     <= adj_mem[adj_rd_addr];
         adj_rd_vld_ff <= adj_vld_ff[adj_rd_addr];
         adj_rd_idx_ff <= adj_rd_addr;
      end
      if (cmd.adj_wr) begin
         adj_mem[src_idx] <= adj_row | (ROW_W'(1) << dst_idx);
      end
   end

   // Closure memory.
   assign clo_rd_en   = cmd.piv_rd || cmd.row_rd || cmd.cnt_rd || cmd.qry_rd;
   always_comb begin
      if (cmd.piv_rd) begin
         clo_rd_addr = k_ff;
      end else if (cmd.qry_rd) begin
         clo_rd_addr = src_idx;
      end else begin
         clo_rd_addr = i_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (clo_rd_en) begin
         clo_rd_ff <= clo_mem[clo_rd_addr];
      end
      if (cmd.cpy_wr) begin
         if (COUNT_W'(i_ff) < n_eff) begin
            clo_mem[i_ff] <= (adj_row | (ROW_W'(1) << i_ff)) & mask;
         end else begin
            clo_mem[i_ff] <= '0;
         end
      end else if (cmd.row_wr && clo_rd_ff[k_ff]) begin
         clo_mem[i_ff] <= clo_rd_ff | pivot_ff;
      end
   end

   // Result word.
   always_comb begin
      rsp_in = '0;
      unique case (item_ff.op)
         OP_CLEAR: begin
            rsp_in.status = STATUS_OK;
         end
         OP_ADD: begin
            rsp_in.status = sts.range_err ? STATUS_RANGE : STATUS_OK;
         end
         OP_COMPUTE: begin
            rsp_in.pair_count = pair_total_ff;
         end
         OP_QUERY: begin
            if (sts.range_err) begin
               rsp_in.status = STATUS_RANGE;
            end else if (!valid_ff) begin
               rsp_in.status = STATUS_INVALID;
            end else begin
               rsp_in.reachable_row = 64'(qry_row);
               rsp_in.reachable     = qry_row[dst_idx];
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/tce_controller.sv -----
// ----------------------------------------------------------------------------
// tce_controller
// Sequencer for the transitive closure engine: accepts a word, steps the
// datapath through the memory passes of that operation and loads the result.
// ----------------------------------------------------------------------------
module tce_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_op,
   output logic                 req_stall,
   input  tce_pkg::tce_sts_type sts,
   output tce_pkg::tce_cmd_type cmd
);
   import tce_pkg::*;

   tce_state_type state_ff;
   tce_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               unique case (req_op)
                  OP_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = S_RESP;
                  end
                  OP_ADD: begin
                     state_in = S_ADD_RD;
                  end
                  OP_COMPUTE: begin
                     cmd.i_zero = 1'b1;
                     state_in   = S_CPY_RD;
                  end
                  OP_QUERY: begin
                     state_in = S_QRY_RD;
                  end
               endcase
            end
         end
         S_ADD_RD: begin
            if (sts.range_err) begin
               state_in = S_RESP;
            end else begin
               cmd.adj_rd = 1'b1;
               state_in   = S_ADD_WR;
            end
         end
         S_ADD_WR: begin
            cmd.adj_wr = 1'b1;
            state_in   = S_RESP;
         end
         S_CPY_RD: begin
            cmd.cpy_rd = 1'b1;
            state_in   = S_CPY_WR;
         end
         S_CPY_WR: begin
            cmd.cpy_wr = 1'b1;
            if (sts.copy_last) begin
               cmd.k_zero = 1'b1;
               state_in   = S_PIV_RD;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = S_CPY_RD;
            end
         end
         S_PIV_RD: begin
            cmd.piv_rd = 1'b1;
            state_in   = S_PIV_LD;
         end
         S_PIV_LD: begin
            cmd.piv_ld = 1'b1;
            cmd.i_zero = 1'b1;
            state_in   = S_ROW_RD;
         end
         S_ROW_RD: begin
            cmd.row_rd = 1'b1;
            state_in   = S_ROW_WR;
         end
         S_ROW_WR: begin
            cmd.row_wr = 1'b1;
            if (!sts.row_last) begin
               cmd.i_inc = 1'b1;
               state_in  = S_ROW_RD;
            end else if (sts.pivot_last) begin
               cmd.i_zero  = 1'b1;
               cmd.acc_clr = 1'b1;
               state_in    = S_CNT_RD;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = S_PIV_RD;
            end
         end
         S_CNT_RD: begin
            cmd.cnt_rd = 1'b1;
            state_in   = S_CNT_ACC;
         end
         S_CNT_ACC: begin
            cmd.cnt_acc = 1'b1;
            if (sts.row_last) begin
               cmd.cnt_done = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = S_CNT_RD;
            end
         end
         S_QRY_RD: begin
            if (!sts.range_err && sts.closure_valid) begin
               cmd.qry_rd = 1'b1;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/transitive_closure_engine.sv -----
// ----------------------------------------------------------------------------
// transitive_closure_engine
// Directed graph reachability engine: edge list held as a bit matrix, with
// bit-parallel Warshall closure, pair counting and reachability queries.
// ----------------------------------------------------------------------------
// Usage. Each word on the req_ channel carries an operation (clear, add
// edge, compute closure, query) and two vertex numbers; each accepted word
// gives exactly one word on the rsp_ channel. A word is taken when its valid
// is high and its stall is low. The block handles one word at a time and
// holds req_stall high from acceptance until its result is in the output
// register; a new word may be taken while that result still waits.
// Clear goes straight to the result; add edge reads and rewrites the source
// adjacency row unless out of range; query reads one closure row unless it
// fails. Compute copies all MAX_VERTICES adjacency rows, merges each active
// pivot row into each active row and then counts the pairs row by row; the
// closure memory has one read port, so a merge visit reads, then writes.
// The vertex count is written through csr_wr_en and csr_wr_data, by the user
// only while the block is idle (the block does not enforce this); a write discards any computed closure.
// Reset (synchronous, active high) restores the identity adjacency, drops
// the closure, sets the vertex count to 64 and empties the output register.
// While rsp_stall is high the result word holds, and a finished operation
// waits before its result is loaded.
// ----------------------------------------------------------------------------
module transitive_closure_engine #(
   parameter int MAX_VERTICES = tce_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  tce_pkg::tce_req_type         req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output tce_pkg::tce_rsp_type         rsp_data,
   input  logic                         csr_wr_en,
   input  logic [tce_pkg::COUNT_W-1:0]  csr_wr_data
);
   import tce_pkg::*;

   // Commands from the sequencer and status back from the datapath.
   tce_cmd_type cmd;
   tce_sts_type sts;

   // The sequencer steps through the memory passes of each operation.
   tce_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds both row memories, the counters and the result word.
   tce_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cmd         (cmd),
      .sts         (sts),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
